### sv/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, register map, command codes and saturation helper for the
// PID step core.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int ADDR_W = 5;

   // register byte addresses
   localparam logic [ADDR_W-1:0] REG_GAIN_P     = 5'd0;
   localparam logic [ADDR_W-1:0] REG_GAIN_I     = 5'd4;
   localparam logic [ADDR_W-1:0] REG_GAIN_D     = 5'd8;
   localparam logic [ADDR_W-1:0] REG_STEP_TIME  = 5'd12;
   localparam logic [ADDR_W-1:0] REG_STEP_RATE  = 5'd16;
   localparam logic [ADDR_W-1:0] REG_INT_LIMIT  = 5'd20;
   localparam logic [ADDR_W-1:0] REG_OUT_LIMIT  = 5'd24;

   // transaction kinds
   localparam logic [1:0] KIND_UPDATE    = 2'd0;
   localparam logic [1:0] KIND_CLEAR_ALL = 2'd1;
   localparam logic [1:0] KIND_CLEAR_INT = 2'd2;

   localparam logic [30:0] INT_LIMIT_RESET = 31'h7FFF_FFFF;

   // shared multiplier operand widths
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   typedef struct packed {
      logic signed [15:0] gain_p;
      logic signed [15:0] gain_i;
      logic signed [15:0] gain_d;
      logic [15:0]        step_time;
      logic [15:0]        step_rate;
      logic [30:0]        integral_limit;
      logic [30:0]        output_limit;
   } pidc_cfg_type;

   localparam pidc_cfg_type CFG_RESET = '{
      gain_p:         16'sd0,
      gain_i:         16'sd0,
      gain_d:         16'sd0,
      step_time:      16'd0,
      step_rate:      16'd0,
      integral_limit: INT_LIMIT_RESET,
      output_limit:   31'd0
   };

   localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(64'sd2147483647);
   localparam logic signed [PROD_W-1:0] S32_MIN = PROD_W'(-64'sd2147483648);

   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < S32_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### sv/pidc_csr.sv
// ----------------------------------------------------------------------------
// pidc_csr
// APB register file holding gains, sample timing and the two limits.
// ----------------------------------------------------------------------------
module pidc_csr
   import pidc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output pidc_cfg_type      cfg
);

   pidc_cfg_type cfg_ff, cfg_in;
   logic         wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr)
            REG_GAIN_P:    cfg_in.gain_p         = pwdata[15:0];
            REG_GAIN_I:    cfg_in.gain_i         = pwdata[15:0];
            REG_GAIN_D:    cfg_in.gain_d         = pwdata[15:0];
            REG_STEP_TIME: cfg_in.step_time      = pwdata[15:0];
            REG_STEP_RATE: cfg_in.step_rate      = pwdata[15:0];
            REG_INT_LIMIT: cfg_in.integral_limit = pwdata[30:0];
            REG_OUT_LIMIT: cfg_in.output_limit   = pwdata[30:0];
            default:       cfg_in                = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr)
         REG_GAIN_P:    prdata = {16'd0, cfg_ff.gain_p};
         REG_GAIN_I:    prdata = {16'd0, cfg_ff.gain_i};
         REG_GAIN_D:    prdata = {16'd0, cfg_ff.gain_d};
         REG_STEP_TIME: prdata = {16'd0, cfg_ff.step_time};
         REG_STEP_RATE: prdata = {16'd0, cfg_ff.step_rate};
         REG_INT_LIMIT: prdata = {1'b0, cfg_ff.integral_limit};
         REG_OUT_LIMIT: prdata = {1'b0, cfg_ff.output_limit};
         default:       prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/pidc_mul.sv
// ----------------------------------------------------------------------------
// pidc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pidc_mul
   import pidc_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic signed [MUL_B_W-1:0] op_b,
   output logic signed [PROD_W-1:0]  prod
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### sv/pid_controller_step_core.sv
// ----------------------------------------------------------------------------
// pid_controller_step_core
// PID step with integral clamp and output-clamp anti-windup.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. For an accepted update the single
// shared multiplier is used five times in turn (error times step_time, P, I,
// D, then D times step_rate), followed by a summing state and a clamp and
// writeback state. Clear commands and the unused kind go to a single zero
// state and return all-zero results. req_stall is high from acceptance
// until the result is loaded into the output register; the final state holds
// while a previous result is still stalled on the rsp side.
// ----------------------------------------------------------------------------
module pid_controller_step_core
   import pidc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // input channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_kind,
   input  logic signed [15:0]  req_error,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_drive,
   output logic signed [31:0]  rsp_p_term,
   output logic signed [31:0]  rsp_i_term,
   output logic signed [31:0]  rsp_d_term,
   output logic                rsp_clamped,
   // configuration
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_INC   = 4'd1;
   localparam logic [3:0] ST_INTEG = 4'd2;
   localparam logic [3:0] ST_P     = 4'd3;
   localparam logic [3:0] ST_I     = 4'd4;
   localparam logic [3:0] ST_D1    = 4'd5;
   localparam logic [3:0] ST_D2    = 4'd6;
   localparam logic [3:0] ST_SUM   = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;
   localparam logic [3:0] ST_ZERO  = 4'd9;

   pidc_cfg_type cfg;

   logic [3:0]                state_ff, state_in;
   logic signed [15:0]        e_ff, e_in;
   logic signed [31:0]        isum_ff, isum_in;
   logic signed [15:0]        prev_ff, prev_in;
   logic signed [31:0]        inc_ff, inc_in;
   logic signed [31:0]        integ_ff, integ_in;
   logic signed [31:0]        p_ff, p_in;
   logic signed [31:0]        i_ff, i_in;
   logic signed [31:0]        d_ff, d_in;
   logic signed [31:0]        sum_ff, sum_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]        drive_ff, drive_in;
   logic signed [31:0]        rp_ff, rp_in;
   logic signed [31:0]        ri_ff, ri_in;
   logic signed [31:0]        rd_ff, rd_in;
   logic                      clamp_ff, clamp_in;

   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [PROD_W-1:0]  prod;

   logic                      accept;
   logic                      out_free;
   logic signed [32:0]        integ_raw;
   logic signed [32:0]        ilim;
   logic signed [32:0]        ilim_neg;
   logic signed [16:0]        diff;
   logic signed [33:0]        sum_raw;
   logic signed [31:0]        olim;
   logic signed [32:0]        takeback;
   logic signed [PROD_W-1:0]  i_shift;
   logic                      gd_pos;

   pidc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pidc_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = drive_ff;
   assign rsp_p_term  = rp_ff;
   assign rsp_i_term  = ri_ff;
   assign rsp_d_term  = rd_ff;
   assign rsp_clamped = clamp_ff;

   assign diff      = {e_ff[15], e_ff} - {prev_ff[15], prev_ff};
   // prod holds error times step_time while in ST_INTEG
   assign integ_raw = {isum_ff[31], isum_ff} + {prod[31], prod[31:0]};
   assign ilim      = {2'b00, cfg.integral_limit};
   assign ilim_neg  = -ilim;
   assign sum_raw   = {{2{p_ff[31]}}, p_ff} + {{2{i_ff[31]}}, i_ff} + {{2{d_ff[31]}}, d_ff};
   assign olim      = {1'b0, cfg.output_limit};
   assign takeback  = {integ_ff[31], integ_ff} - {inc_ff[31], inc_ff};
   assign i_shift   = prod >>> 16;  // floor toward minus infinity
   assign gd_pos    = !cfg.gain_d[15] && (cfg.gain_d != 16'sd0);

   // operand select for the shared multiplier
   always_comb begin
      case (state_ff)
         ST_INC: begin
            op_a = {{17{e_ff[15]}}, e_ff};
            op_b = {2'b00, cfg.step_time};
         end
         ST_INTEG: begin
            op_a = {{17{e_ff[15]}}, e_ff};
            op_b = {{2{cfg.gain_p[15]}}, cfg.gain_p};
         end
         ST_P: begin
            op_a = {integ_ff[31], integ_ff};
            op_b = {{2{cfg.gain_i[15]}}, cfg.gain_i};
         end
         ST_I: begin
            op_a = {{16{diff[16]}}, diff};
            op_b = {{2{cfg.gain_d[15]}}, cfg.gain_d};
         end
         ST_D1: begin
            op_a = prod[MUL_A_W-1:0];
            op_b = {2'b00, cfg.step_rate};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      e_in         = e_ff;
      isum_in      = isum_ff;
      prev_in      = prev_ff;
      inc_in       = inc_ff;
      integ_in     = integ_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      drive_in     = drive_ff;
      rp_in        = rp_ff;
      ri_in        = ri_ff;
      rd_in        = rd_ff;
      clamp_in     = clamp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               e_in = req_error;
               case (req_kind)
                  KIND_UPDATE: begin
                     state_in = ST_INC;
                  end
                  KIND_CLEAR_ALL: begin
                     isum_in  = '0;
                     prev_in  = '0;
                     state_in = ST_ZERO;
                  end
                  KIND_CLEAR_INT: begin
                     isum_in  = '0;
                     state_in = ST_ZERO;
                  end
                  default: begin
                     state_in = ST_ZERO;
                  end
               endcase
            end
         end
         ST_INC: begin
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            inc_in = prod[31:0];
            // clamp the new integral so the I multiply can use it next cycle
            if (integ_raw > ilim) begin
               integ_in = ilim[31:0];
            end else if (integ_raw < ilim_neg) begin
               integ_in = ilim_neg[31:0];
            end else begin
               integ_in = integ_raw[31:0];
            end
            state_in = ST_P;
         end
         ST_P: begin
            p_in     = sat32(prod);
            state_in = ST_I;
         end
         ST_I: begin
            i_in     = sat32(i_shift);
            state_in = ST_D1;
         end
         ST_D1: begin
            state_in = ST_D2;
         end
         ST_D2: begin
            d_in     = gd_pos ? sat32(prod) : 32'sd0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in   = sat32({{(PROD_W-34){sum_raw[33]}}, sum_raw});
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               drive_in = sum_ff;
               clamp_in = 1'b0;
               isum_in  = integ_ff;
               if (olim != 32'sd0) begin
                  if (sum_ff > olim) begin
                     drive_in = olim;
                     clamp_in = 1'b1;
                     if (inc_ff > 32'sd0) begin
                        isum_in = sat32({{(PROD_W-33){takeback[32]}}, takeback});
                     end
                  end else if (sum_ff < -olim) begin
                     drive_in = -olim;
                     clamp_in = 1'b1;
                     if (inc_ff < 32'sd0) begin
                        isum_in = sat32({{(PROD_W-33){takeback[32]}}, takeback});
                     end
                  end
               end
               prev_in      = e_ff;
               rp_in        = p_ff;
               ri_in        = i_ff;
               rd_in        = d_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               drive_in     = '0;
               rp_in        = '0;
               ri_in        = '0;
               rd_in        = '0;
               clamp_in     = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         isum_ff      <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         isum_ff      <= isum_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff     <= e_in;
      inc_ff   <= inc_in;
      integ_ff <= integ_in;
      p_ff     <= p_in;
      i_ff     <= i_in;
      d_ff     <= d_in;
      sum_ff   <= sum_in;
      drive_ff <= drive_in;
      rp_ff    <= rp_in;
      ri_ff    <= ri_in;
      rd_ff    <= rd_in;
      clamp_ff <= clamp_in;
   end

endmodule
